[rtl/time_ordered_event_queue_defines.svh]
// Assertion macros shared by the event queue checker.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef TIME_ORDERED_EVENT_QUEUE_DEFINES_SVH
`define TIME_ORDERED_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TOEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TOEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/toeq_pkg.sv]
// Shared constants, status codes and the entry type of the event queue.
// Depends on nothing.
package toeq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    typedef struct packed {
        logic [7:0]  event_code;
        logic [9:0]  agent_code;
        logic [31:0] seconds;
        logic [29:0] nanos;
    } entry_t;

endpackage

[rtl/toeq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module toeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/toeq_cmp.sv]
// Time compare unit: is the new time strictly later than a stored one.
// Depends on toeq_pkg.
module toeq_cmp
    import toeq_pkg::*;
(
    input  entry_t new_entry,
    input  entry_t old_entry,
    output logic   later
);

    always_comb
    begin
        if (new_entry.seconds != old_entry.seconds)
        begin
            later = new_entry.seconds > old_entry.seconds;
        end
        else
        begin
            later = new_entry.nanos > old_entry.nanos;
        end
    end

endmodule

[rtl/time_ordered_event_queue.sv]
// A pop gives its result strobe from S_POP after the registered RAM read, a full
// insert or an empty pop straight from S_IDLE, and an insert from S_PLACE.
// An insert scans from the earliest entry, moving each entry earlier than the new time
// up one slot until a later or equal entry stops it; busy stays high meanwhile and
// a new request is taken as early as the cycle its result strobe shows.
// Reset (rst_n low, asynchronous) empties the queue; RAM contents are not cleared.
module time_ordered_event_queue
    import toeq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  event_code,
    input  logic [9:0]  agent_code,
    input  logic [31:0] time_seconds,
    input  logic [29:0] time_nanos,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  out_event,
    output logic [9:0]  out_agent,
    output logic [31:0] out_seconds,
    output logic [29:0] out_nanos
);

    // The RAM holds entries with the earliest at the highest address (count - 1),
    // so a pop reads one word and an insert shifts only the earlier entries up.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_PLACE = 2'd2;
    localparam logic [1:0] S_POP   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    entry_t            new_reg, new_next;

    logic              done_reg;
    logic [1:0]        status_reg;
    entry_t            out_reg;

    logic              res_valid;
    logic [1:0]        res_status;
    entry_t            res_entry;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    entry_t            ram_rdata;
    logic              later;
    logic [CNT_W-1:0]  count_m1;

    toeq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH),
        .AW    (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    toeq_cmp u_cmp (
        .new_entry (new_reg),
        .old_entry (ram_rdata),
        .later     (later)
    );

    assign count_m1 = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        new_next   = new_reg;
        ram_we     = 1'b0;
        ram_waddr  = k_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = count_m1[ADDR_W-1:0];
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_entry  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    new_next.event_code = event_code;
                    new_next.agent_code = agent_code;
                    new_next.seconds    = time_seconds;
                    new_next.nanos      = time_nanos;
                    if (mode == MODE_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            res_valid  = 1'b1;
                            res_status = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    else if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_FULL;
                    end
                    else if (count_reg == '0)
                    begin
                        k_next     = '0;
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        k_next     = count_reg[ADDR_W-1:0];
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Read data holds the entry just below slot k.
                if (later)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = k_reg;
                    ram_wdata = ram_rdata;
                    k_next    = k_reg - ADDR_W'(1);
                    if (k_reg > ADDR_W'(1))
                    begin
                        ram_raddr = k_reg - ADDR_W'(2);
                    end
                    else
                    begin
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = k_reg;
                ram_wdata  = new_reg;
                count_next = count_reg + CNT_W'(1);
                res_valid  = 1'b1;
                res_status = ST_OK;
                state_next = S_IDLE;
            end
            S_POP:
            begin
                count_next = count_m1;
                res_valid  = 1'b1;
                res_status = ST_OK;
                res_entry  = ram_rdata;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        new_reg <= new_next;
        if (res_valid)
        begin
            status_reg <= res_status;
            out_reg    <= res_entry;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign out_event   = out_reg.event_code;
    assign out_agent   = out_reg.agent_code;
    assign out_seconds = out_reg.seconds;
    assign out_nanos   = out_reg.nanos;

endmodule

[rtl/toeq_checker.sv]
// Port-level checks of the event queue and the bind that attaches them.
// Depends on toeq_pkg and time_ordered_event_queue_defines.svh.
`include "time_ordered_event_queue_defines.svh"

module toeq_checker
    import toeq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [7:0]  out_event,
    input logic [9:0]  out_agent,
    input logic [31:0] out_seconds,
    input logic [29:0] out_nanos
);

    // A request either keeps the block busy or finishes in the next cycle.
    `TOEQ_ASSERT_NEXT(a_req_progress, start && !busy, busy || done, "request lost")
    // Every result shows while the sequencer is idle.
    `TOEQ_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
    // Leaving busy always delivers a result.
    `TOEQ_ASSERT_NOW(a_fell_done, $fell(busy), done, "busy ended with no result")
    // Failed requests return zero payload.
    `TOEQ_ASSERT_NOW(a_zero_payload, done && (status != ST_OK),
        (out_event == 8'd0) && (out_agent == 10'd0) && (out_seconds == 32'd0)
        && (out_nanos == 30'd0), "nonzero payload on failed request")
    `TOEQ_ASSERT_NOW(a_status_code, done,
        (status == ST_OK) || (status == ST_FULL) || (status == ST_EMPTY),
        "bad status code")

endmodule

bind time_ordered_event_queue toeq_checker u_toeq_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the time-ordered event queue: directed table, then random traffic.
// Depends on toeq_pkg and time_ordered_event_queue; a shadow sorted queue predicts each result a row does not give.
module tb;
    import toeq_pkg::*;

    localparam int RANDOM_REQUESTS = 1200;
    localparam int STALL_LIMIT     = 2000;

    typedef struct packed {
        logic        mode;
        logic [7:0]  ev;
        logic [9:0]  ag;
        logic [31:0] sec;
        logic [29:0] ns;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  ev;
        logic [9:0]  ag;
        logic [31:0] sec;
        logic [29:0] ns;
    } outcome_t;

    typedef struct {
        request_t req;
        bit       typed;
        outcome_t want;
    } table_row_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic        mode         = MODE_INSERT;
    logic [7:0]  event_code   = '0;
    logic [9:0]  agent_code   = '0;
    logic [31:0] time_seconds = '0;
    logic [29:0] time_nanos   = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  out_event;
    logic [9:0]  out_agent;
    logic [31:0] out_seconds;
    logic [29:0] out_nanos;

    entry_t     shadow_events[$];
    outcome_t   expected_outcomes[$];
    table_row_t directed_rows[$];
    outcome_t   oldest;

    int errors       = 0;
    int checked      = 0;
    int inserts      = 0;
    int pops         = 0;
    int full_drops   = 0;
    int empty_pops   = 0;
    int idle_cycles  = 0;

    time_ordered_event_queue uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .event_code   (event_code),
        .agent_code   (agent_code),
        .time_seconds (time_seconds),
        .time_nanos   (time_nanos),
        .done         (done),
        .status       (status),
        .out_event    (out_event),
        .out_agent    (out_agent),
        .out_seconds  (out_seconds),
        .out_nanos    (out_nanos)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit is_later(logic [31:0] sec, logic [29:0] ns, entry_t e);
        if (sec != e.seconds)
            return sec > e.seconds;
        return ns > e.nanos;
    endfunction

    // Applies one request to the shadow queue and returns the result it should produce.
    function automatic outcome_t shadow_step(request_t r);
        outcome_t o;
        entry_t   e;
        int       pos;
        o = '0;
        o.status = ST_OK;
        if (r.mode == MODE_INSERT)
        begin
            inserts++;
            if (shadow_events.size() >= QUEUE_DEPTH)
            begin
                o.status = ST_FULL;
                full_drops++;
            end
            else
            begin
                pos = 0;
                while (pos < shadow_events.size() && is_later(r.sec, r.ns, shadow_events[pos]))
                    pos++;
                e.event_code = r.ev;
                e.agent_code = r.ag;
                e.seconds    = r.sec;
                e.nanos      = r.ns;
                shadow_events.insert(pos, e);
            end
        end
        else
        begin
            pops++;
            if (shadow_events.size() == 0)
            begin
                o.status = ST_EMPTY;
                empty_pops++;
            end
            else
            begin
                e     = shadow_events.pop_front();
                o.ev  = e.event_code;
                o.ag  = e.agent_code;
                o.sec = e.seconds;
                o.ns  = e.nanos;
            end
        end
        return o;
    endfunction

    function automatic request_t random_request(int insert_pct);
        request_t    r;
        logic [31:0] bits;
        r.mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_POP;
        bits = $urandom();
        r.ev = bits[7:0];
        r.ag = bits[17:8];
        // Small time ranges make ties and reordering common; wide ones hit the upper bits.
        case ($urandom_range(0, 4))
            0, 1:    r.sec = $urandom_range(0, 7);
            2:       r.sec = $urandom_range(0, 1000);
            3:       r.sec = $urandom();
            default: r.sec = 32'hFFFF_FFFF - $urandom_range(0, 3);
        endcase
        bits = $urandom();
        case ($urandom_range(0, 9))
            7, 8:    r.ns = 30'($urandom_range(0, 2));
            9:       r.ns = bits[29:0];
            default: r.ns = 30'($urandom_range(0, 999999999));
        endcase
        return r;
    endfunction

    function automatic table_row_t make_row(logic m, logic [7:0] ev, logic [9:0] ag,
                                            logic [31:0] sec, logic [29:0] ns,
                                            bit typed, logic [1:0] st);
        table_row_t row;
        row.req.mode    = m;
        row.req.ev      = ev;
        row.req.ag      = ag;
        row.req.sec     = sec;
        row.req.ns      = ns;
        row.typed       = typed;
        row.want        = '0;
        row.want.status = st;
        return row;
    endfunction

    // Leaves start high after acceptance; the caller lowers it when it idles.
    task automatic send_request(request_t r, bit typed, outcome_t want);
        outcome_t predicted;
        start        <= 1'b1;
        mode         <= r.mode;
        event_code   <= r.ev;
        agent_code   <= r.ag;
        time_seconds <= r.sec;
        time_nanos   <= r.ns;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = shadow_step(r);
        expected_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request pending, status %0h", $time, status);
            end
            else
            begin
                oldest = expected_outcomes.pop_front();
                checked++;
                report_field("status", 32'(oldest.status), 32'(status));
                report_field("out_event", 32'(oldest.ev), 32'(out_event));
                report_field("out_agent", 32'(oldest.ag), 32'(out_agent));
                report_field("out_seconds", oldest.sec, out_seconds);
                report_field("out_nanos", 32'(oldest.ns), 32'(out_nanos));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && busy === 1'b0) || done === 1'b1)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int  sent;
        int  seg_left;
        int  burst_left;
        int  gap;
        int  gap_max;
        int  insert_pct;
        bit  hold;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_rows.push_back(make_row(MODE_POP, 8'd0, 10'd0, 32'd0, 30'd0, 1, ST_EMPTY));
        directed_rows.push_back(make_row(MODE_INSERT, 8'hFF, 10'h3FF, 32'hFFFF_FFFF,
                                         30'h3FFF_FFFF, 1, ST_OK));
        directed_rows.push_back(make_row(MODE_INSERT, 8'h00, 10'h000, 32'd0, 30'd0, 1, ST_OK));
        // Two requests with the same time: the later one must come out first.
        directed_rows.push_back(make_row(MODE_INSERT, 8'h5A, 10'h2A5, 32'd1000, 30'd999999999,
                                         1, ST_OK));
        directed_rows.push_back(make_row(MODE_INSERT, 8'hA5, 10'h15A, 32'd1000, 30'd999999999,
                                         1, ST_OK));
        directed_rows.push_back(make_row(MODE_POP, 8'h11, 10'h22, 32'd3, 30'd4, 0, ST_OK));
        directed_rows.push_back(make_row(MODE_POP, 8'h33, 10'h44, 32'd5, 30'd6, 0, ST_OK));
        // Nanoseconds past one second compare as a raw value, with no carry.
        directed_rows.push_back(make_row(MODE_INSERT, 8'h3C, 10'h0C3, 32'd1000, 30'd1000000000,
                                         1, ST_OK));
        for (int i = 0; i < QUEUE_DEPTH - 3; i++)
            directed_rows.push_back(make_row(MODE_INSERT, 8'(i * 17), 10'(i * 61),
                                             32'(500 - 31 * i), 30'(i * 77777), 1, ST_OK));
        directed_rows.push_back(make_row(MODE_INSERT, 8'h77, 10'h177, 32'd0, 30'd0, 1, ST_FULL));
        for (int i = 0; i < 3; i++)
            directed_rows.push_back(make_row(MODE_POP, 8'd0, 10'd0, 32'd0, 30'd0, 0, ST_OK));

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // Let the queue drain its pending results before random traffic begins.
        start <= 1'b0;
        @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);

        sent       = 0;
        seg_left   = 0;
        burst_left = 0;
        insert_pct = 50;
        gap_max    = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            hold = 0;
            gap  = 0;
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 60);
                case ($urandom_range(0, 3))
                    0:       insert_pct = 20;
                    1:       insert_pct = 50;
                    2:       insert_pct = 70;
                    default: insert_pct = 90;
                endcase
                gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                hold    = ($urandom_range(0, 3) == 0);
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(0, gap_max);
            end
            if (hold || gap > 0)
            begin
                start <= 1'b0;
                repeat ((gap > 0) ? gap : 1) @(posedge clk);
                while (hold && expected_outcomes.size() != 0)
                    @(posedge clk);
            end
            send_request(random_request(insert_pct), 0, '0);
            sent++;
            seg_left--;
            burst_left--;
        end

        start <= 1'b0;
        @(posedge clk);
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (QUEUE_DEPTH + 4) @(posedge clk);

        $display("Checked %0d results from %0d requests (%0d inserts, %0d pops).",
                 checked, inserts + pops, inserts, pops);
        $display("Inserts dropped on a full queue: %0d, pops on an empty queue: %0d.",
                 full_drops, empty_pops);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
